// ===== rtl/rwsp_pkg.sv =====
package rwsp_pkg;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned ERR_W       = 3;

  // Four-character tags, first character in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] PCM_CODE     = 16'd1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NOT_RIFF = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_WAVE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NOT_PCM  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CHUNK    = 3'd4;

  typedef enum logic [8:0] {
    PH_RIFF  = 9'b0_0000_0001,
    PH_RSIZE = 9'b0_0000_0010,
    PH_WAVE  = 9'b0_0000_0100,
    PH_CID   = 9'b0_0000_1000,
    PH_CSIZE = 9'b0_0001_0000,
    PH_FMT   = 9'b0_0010_0000,
    PH_SKIP  = 9'b0_0100_0000,
    PH_DATA  = 9'b0_1000_0000,
    PH_IDLE  = 9'b1_0000_0000
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        data_byte;
    logic [15:0]       channels;
    logic [31:0]       sample_rate;
    logic [15:0]       sample_bits;
    logic [ERR_W-1:0]  error_code;
    logic              last_data;
  } result_t;

endpackage

// ===== rtl/riff_wave_stream_parser_unit.sv =====
// RIFF/WAVE stream parser.
//
// Input channel s_axis: one file byte per beat in tdata. tuser high marks the
// first byte of a new file and restarts parsing; tlast marks the final byte
// of the file. The parser checks the RIFF and WAVE tags, walks the chunks,
// reads channels, rate and bits from the fmt chunk and skips other chunks.
//
// Output channel m_axis: tuser gives the kind of beat (audio byte, format
// report or error report). A format report comes out when the data chunk
// header completes; every data chunk byte then follows as an audio beat, the
// final one with tlast. Header bytes, skipped chunk bytes and anything after
// the data chunk or an error produce no beat.
//
// Timing: an input register and a result register, with the state update in
// between. An accepted byte waits in the input register; its result moves to
// the result register once that is free or draining. One byte is taken every
// cycle while the receiver keeps up. When m_axis_tready is low the result
// register holds and the input register fills; s_axis_tready drops only once
// both are occupied.
//
// Reset (rst, synchronous): both registers empty, parser waits for a RIFF tag.
module riff_wave_stream_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [rwsp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] in_byte
  input  logic                                 s_axis_tuser,  // [0] new_file
  input  logic                                 s_axis_tlast,  // end_of_input
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] data_byte, [23:8] channels, [55:24] sample_rate,
  // [71:56] sample_bits, [74:72] error_code, [79:75] zero
  output logic [rwsp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [rwsp_pkg::KIND_W-1:0]          m_axis_tuser,  // [1:0] kind
  output logic                                 m_axis_tlast   // last_data
);
  import rwsp_pkg::*;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_new;
  logic       in_end;

  // Result register
  logic    out_valid;
  result_t out_res;

  // Parser state
  phase_t      phase;
  logic [4:0]  field_index;
  logic [31:0] tag_shift;
  logic [31:0] chunk_length;
  logic [31:0] skip_left;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] rate_value;
  logic [15:0] bits_value;
  logic        format_seen;
  logic [31:0] data_left;

  phase_t      phase_next;
  logic [4:0]  field_index_next;
  logic [31:0] tag_shift_next;
  logic [31:0] chunk_length_next;
  logic [31:0] skip_left_next;
  logic [15:0] format_code_next;
  logic [15:0] channel_count_next;
  logic [31:0] rate_value_next;
  logic [15:0] bits_value_next;
  logic        format_seen_next;
  logic [31:0] data_left_next;

  // Working copies after an optional restart on new_file
  phase_t      ph;
  logic [4:0]  idx;
  logic [31:0] tag;
  logic [31:0] clen;
  logic [31:0] skip;
  logic [15:0] fcode;
  logic [15:0] chan;
  logic [31:0] rate;
  logic [15:0] bits;
  logic        fseen;
  logic [31:0] dleft;

  logic [31:0] tag_sh;
  logic [31:0] clen_sh;
  logic [15:0] fcode_upd;
  logic [31:0] skip_dec;
  logic [31:0] dleft_dec;

  result_t res;
  logic    res_valid;
  logic    advance;

  // Move the held byte into the result stage when that stage is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    ph    = in_new ? PH_RIFF : phase;
    idx   = in_new ? 5'd0  : field_index;
    tag   = in_new ? 32'd0 : tag_shift;
    clen  = in_new ? 32'd0 : chunk_length;
    skip  = in_new ? 32'd0 : skip_left;
    fcode = in_new ? 16'd0 : format_code;
    chan  = in_new ? 16'd0 : channel_count;
    rate  = in_new ? 32'd0 : rate_value;
    bits  = in_new ? 16'd0 : bits_value;
    fseen = in_new ? 1'b0  : format_seen;
    dleft = in_new ? 32'd0 : data_left;

    phase_next         = ph;
    field_index_next   = idx;
    tag_shift_next     = tag;
    chunk_length_next  = clen;
    skip_left_next     = skip;
    format_code_next   = fcode;
    channel_count_next = chan;
    rate_value_next    = rate;
    bits_value_next    = bits;
    format_seen_next   = fseen;
    data_left_next     = dleft;

    res       = '0;
    res_valid = 1'b0;

    tag_sh    = {tag[23:0], in_byte};
    clen_sh   = clen | ({24'd0, in_byte} << {idx[1:0], 3'b000});
    fcode_upd = fcode;
    skip_dec  = skip - 32'd1;
    dleft_dec = dleft - 32'd1;

    unique case (ph) inside
      PH_RIFF, PH_WAVE, PH_CID: begin
        tag_shift_next = tag_sh;
        if (idx >= 5'd3) begin
          field_index_next = 5'd0;
          if (ph == PH_RIFF) begin
            if (tag_sh != TAG_RIFF) begin
              res.kind = KIND_ERROR; res.error_code = ERR_NOT_RIFF;
              res_valid = 1'b1; phase_next = PH_IDLE;
            end else begin
              phase_next = PH_RSIZE;
            end
          end else if (ph == PH_WAVE) begin
            if (tag_sh != TAG_WAVE) begin
              res.kind = KIND_ERROR; res.error_code = ERR_NOT_WAVE;
              res_valid = 1'b1; phase_next = PH_IDLE;
            end else begin
              phase_next = PH_CID;
            end
          end else begin
            // a data chunk ahead of fmt cannot be decoded
            if (tag_sh == TAG_DATA && !fseen) begin
              res.kind = KIND_ERROR; res.error_code = ERR_CHUNK;
              res_valid = 1'b1; phase_next = PH_IDLE;
            end else begin
              chunk_length_next = 32'd0;
              phase_next        = PH_CSIZE;
            end
          end
        end else begin
          field_index_next = idx + 5'd1;
        end
      end
      PH_RSIZE: begin
        if (idx >= 5'd3) begin
          field_index_next = 5'd0;
          tag_shift_next   = 32'd0;
          phase_next       = PH_WAVE;
        end else begin
          field_index_next = idx + 5'd1;
        end
      end
      PH_CSIZE: begin
        chunk_length_next = clen_sh;
        if (idx < 5'd3) begin
          field_index_next = idx + 5'd1;
        end else begin
          field_index_next = 5'd0;
          if (tag == TAG_FMT) begin
            format_code_next   = 16'd0;
            channel_count_next = 16'd0;
            rate_value_next    = 32'd0;
            bits_value_next    = 16'd0;
            phase_next         = PH_FMT;
          end else if (tag == TAG_DATA) begin
            res.kind        = KIND_FORMAT;
            res.channels    = chan;
            res.sample_rate = rate;
            res.sample_bits = bits;
            res_valid       = 1'b1;
            data_left_next  = clen_sh;
            phase_next      = (clen_sh != 32'd0) ? PH_DATA : PH_IDLE;
          end else begin
            skip_left_next = clen_sh;
            phase_next     = (clen_sh != 32'd0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FMT: begin
        // body: code, channels, rate, byte rate, block align, bits
        if (idx < 5'd2) begin
          fcode_upd = fcode | ({8'd0, in_byte} << {idx[0], 3'b000});
        end else if (idx < 5'd4) begin
          channel_count_next = chan | ({8'd0, in_byte} << {idx[0], 3'b000});
        end else if (idx < 5'd8) begin
          rate_value_next = rate | ({24'd0, in_byte} << {idx[1:0], 3'b000});
        end else if (idx >= 5'd14 && idx < 5'd16) begin
          bits_value_next = bits | ({8'd0, in_byte} << {idx[0], 3'b000});
        end
        format_code_next = fcode_upd;
        if (idx < 5'd15) begin
          field_index_next = idx + 5'd1;
        end else begin
          field_index_next = 5'd0;
          if (fcode_upd != PCM_CODE) begin
            res.kind = KIND_ERROR; res.error_code = ERR_NOT_PCM;
            res_valid = 1'b1; phase_next = PH_IDLE;
          end else begin
            format_seen_next = 1'b1;
            if (clen > FMT_BODY_LEN) begin
              skip_left_next = clen - FMT_BODY_LEN;
              phase_next     = PH_SKIP;
            end else begin
              skip_left_next = 32'd0;
              phase_next     = PH_CID;
            end
          end
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 32'd0) begin
          field_index_next = 5'd0;
          tag_shift_next   = 32'd0;
          phase_next       = PH_CID;
        end
      end
      PH_DATA: begin
        res.kind       = KIND_DATA;
        res.data_byte  = in_byte;
        res_valid      = 1'b1;
        data_left_next = dleft_dec;
        if (dleft_dec == 32'd0) begin
          res.last_data = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // File ends early: report where it stopped, unless this byte already spoke
    if (in_end) begin
      if (!res_valid && ph != PH_DATA && ph != PH_IDLE) begin
        res           = '0;
        res.kind      = KIND_ERROR;
        res_valid     = 1'b1;
        if (ph == PH_RIFF) begin
          res.error_code = ERR_NOT_RIFF;
        end else if (ph == PH_RSIZE || ph == PH_WAVE) begin
          res.error_code = ERR_NOT_WAVE;
        end else begin
          res.error_code = ERR_CHUNK;
        end
      end
      phase_next = PH_IDLE;
    end
  end

  // Input register: take a beat whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_new  <= s_axis_tuser;
      in_end  <= s_axis_tlast;
    end
  end

  // Parser state advances once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      field_index   <= 5'd0;
      tag_shift     <= 32'd0;
      chunk_length  <= 32'd0;
      skip_left     <= 32'd0;
      format_code   <= 16'd0;
      channel_count <= 16'd0;
      rate_value    <= 32'd0;
      bits_value    <= 16'd0;
      format_seen   <= 1'b0;
      data_left     <= 32'd0;
    end else if (advance) begin
      phase         <= phase_next;
      field_index   <= field_index_next;
      tag_shift     <= tag_shift_next;
      chunk_length  <= chunk_length_next;
      skip_left     <= skip_left_next;
      format_code   <= format_code_next;
      channel_count <= channel_count_next;
      rate_value    <= rate_value_next;
      bits_value    <= bits_value_next;
      format_seen   <= format_seen_next;
      data_left     <= data_left_next;
    end
  end

  // Result register: load on advance, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last_data;
  assign m_axis_tdata  = {5'd0, out_res.error_code, out_res.sample_bits,
                          out_res.sample_rate, out_res.channels, out_res.data_byte};

  // A last mark only ever rides on an audio byte
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_DATA)
    else $error("last mark on a non-audio beat");

  // Error beats, and only those, carry a code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tuser == KIND_ERROR) == (out_res.error_code != ERR_NONE)))
    else $error("error code does not match beat kind");

  // The final data byte and any error leave the parser idle
  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && (res.last_data || res.kind == KIND_ERROR)
      |=> phase == PH_IDLE)
    else $error("parser not idle after end of data or error");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
